[src/assert_macros.svh]
// Assertion macros shared by the RTL files of the UTF-8 to UTF-16 transcoder.
// Defining NO_ASSERTIONS turns every macro below into an empty statement.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// The property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// The expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_HOLDS(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

[src/u8u16_pkg.sv]
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
// No dependencies; every RTL module of the block imports this package.
package u8u16_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [15:0] REPL_UNIT = 16'hFFFD;

  // One decoded byte's worth of output: a run of replacement characters
  // followed by zero, one or two code units.
  typedef struct packed {
    logic [2:0]  n_repl;
    logic [1:0]  n_tail;
    logic [15:0] tail0;
    logic [15:0] tail1;
    logic        eot;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[src/u8u16_if.sv]
// Valid/ready channel interfaces for the UTF-8 byte input and UTF-16 unit output.
// No dependencies.
interface u8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface u8u16_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        run_last;
  logic        text_last;

  modport source (output valid, output code_unit, output run_last, output text_last,
                  input ready);
  modport sink (input valid, input code_unit, input run_last, input text_last,
                output ready);
endinterface

[src/utf8_to_utf16_transcoder.sv]
// Top level of the UTF-8 to UTF-16 transcoder: front end, job queue, back end.
// Depends on u8u16_pkg, u8u16_if, u8u16_front, u8u16_queue, u8u16_back and
// assert_macros.svh.
//
//   channel  | dir  | payload                          | beat
//   ---------+------+----------------------------------+-------------------------
//   bytes    | sink | in_byte[7:0], end_of_text        | one UTF-8 byte
//   units    | src  | code_unit[15:0], run_last,       | one UTF-16 code unit
//            |      | text_last                        |
//
// A byte is decoded in the cycle it is taken and its job is registered in the
// queue; its code units leave the back end one per cycle while the output is
// ready, so a plain text moves one byte per cycle. A byte that yields k code
// units holds the back end until all k have left (k is at most four); the
// input keeps flowing until the job queue of QueueDepth entries is full. Reset
// (rst, synchronous) closes any open sequence and empties the queue. The input
// stalls only on a full queue, never on the output's ready in the same cycle.
module utf8_to_utf16_transcoder #(
  parameter int QueueDepth = u8u16_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  u8u16_byte_if.sink   bytes,
  u8u16_unit_if.source units
);
  import u8u16_pkg::*;
  `include "assert_macros.svh"

  job_t          front_job;
  job_t          head_job;
  logic          push;
  logic          pop;
  logic          seq_open;
  queue_status_t q_status;

  // The front decodes each byte against the open sequence and pushes a job
  // describing the run of replacement characters and the decoded units.
  u8u16_front u_front (
    .clk      (clk),
    .rst      (rst),
    .bytes    (bytes),
    .full     (q_status.full),
    .push     (push),
    .job      (front_job),
    .seq_open (seq_open)
  );

  // The queue decouples the two sides so that bursts of replacements or
  // surrogate pairs stall only the output.
  u8u16_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (front_job),
    .pop    (pop),
    .rd_job (head_job),
    .status (q_status)
  );

  // The back end serializes the head job into code-unit beats.
  u8u16_back u_back (
    .clk   (clk),
    .rst   (rst),
    .job   (head_job),
    .empty (q_status.empty),
    .pop   (pop),
    .units (units)
  );

  // A job is never written into a full queue.
  `ASSERT_NEVER(a_no_overflow, clk, rst, push && q_status.full, "job pushed into full queue")
  // Every pushed job carries at least one code unit.
  `ASSERT_HOLDS(a_job_nonempty, clk, rst, push |-> ((front_job.n_repl + {1'b0, front_job.n_tail}) != 3'd0), "empty job pushed")
  // The final byte of a text always leaves the decoder with no sequence open.
  `ASSERT_HOLDS(a_eot_closes, clk, rst, (bytes.valid && bytes.ready && bytes.end_of_text) |=> !seq_open, "sequence still open after end of text")
  // A job leaves the queue only on its final unit.
  `ASSERT_HOLDS(a_pop_on_last, clk, rst, pop |-> (units.valid && units.ready && units.run_last), "queue popped before last unit")

endmodule

[src/u8u16_front.sv]
// Front end: accepts UTF-8 bytes, tracks the open sequence and turns each byte
// into a job for the queue. Depends on u8u16_pkg and u8u16_byte_if.
module u8u16_front (
  input  logic           clk,
  input  logic           rst,
  u8u16_byte_if.sink     bytes,
  input  logic           full,
  output logic           push,
  output u8u16_pkg::job_t job,
  output logic           seq_open
);
  import u8u16_pkg::*;

  logic [1:0]  bytes_expected, bytes_expected_next;
  logic [1:0]  bytes_held, bytes_held_next;
  logic [20:0] partial_value, partial_value_next;

  logic        accept;
  logic [7:0]  b;
  logic        eot;
  logic        is_cont;
  logic [1:0]  held_inc;
  logic [20:0] pv_shift;
  logic        cp_ok;
  logic        fresh;
  logic [1:0]  need;
  logic [20:0] lead_bits;
  logic [19:0] supp;

  assign b            = bytes.in_byte;
  assign eot          = bytes.end_of_text;
  assign bytes.ready  = !full;
  assign accept       = bytes.valid && !full;
  assign seq_open     = (bytes_expected != 2'd0);
  assign is_cont      = (b[7:6] == 2'b10);
  assign held_inc     = bytes_held + 2'd1;
  assign pv_shift     = {partial_value[14:0], b[5:0]};
  assign supp         = pv_shift[19:0] - 20'h10000;

  // Lead byte classification.
  always_comb begin
    need      = 2'd0;
    lead_bits = '0;
    if (b[7:5] == 3'b110) begin
      need      = 2'd1;
      lead_bits = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      need      = 2'd2;
      lead_bits = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      need      = 2'd3;
      lead_bits = {18'd0, b[2:0]};
    end
  end

  // Range check of a completed sequence: no overlong forms, no surrogates,
  // nothing above the last plane.
  always_comb begin
    unique case (bytes_expected)
      2'd1:    cp_ok = (pv_shift >= 21'h80);
      2'd2:    cp_ok = (pv_shift >= 21'h800) &&
                       !((pv_shift >= 21'hD800) && (pv_shift <= 21'hDFFF));
      2'd3:    cp_ok = (pv_shift >= 21'h10000) && (pv_shift <= 21'h10FFFF);
      default: cp_ok = 1'b0;
    endcase
  end

  always_comb begin
    bytes_expected_next = bytes_expected;
    bytes_held_next     = bytes_held;
    partial_value_next  = partial_value;
    job                 = '0;
    job.eot             = eot;
    fresh               = 1'b0;

    if (bytes_expected == 2'd0) begin
      fresh = 1'b1;
    end else if (is_cont) begin
      partial_value_next = pv_shift;
      bytes_held_next    = held_inc;
      if (held_inc == bytes_expected) begin
        bytes_expected_next = 2'd0;
        bytes_held_next     = 2'd0;
        partial_value_next  = '0;
        if (!cp_ok) begin
          job.n_repl = {1'b0, held_inc} + 3'd1;
        end else if (pv_shift <= 21'hFFFF) begin
          job.n_tail = 2'd1;
          job.tail0  = pv_shift[15:0];
        end else begin
          job.n_tail = 2'd2;
          job.tail0  = {6'b110110, supp[19:10]};
          job.tail1  = {6'b110111, supp[9:0]};
        end
      end else if (eot) begin
        job.n_repl = {1'b0, held_inc} + 3'd1;
      end
    end else begin
      // The sequence breaks: the lead and each held byte are rejected and
      // this byte starts over.
      job.n_repl          = {1'b0, bytes_held} + 3'd1;
      bytes_expected_next = 2'd0;
      bytes_held_next     = 2'd0;
      partial_value_next  = '0;
      fresh               = 1'b1;
    end

    if (fresh) begin
      if (!b[7]) begin
        job.n_tail = 2'd1;
        job.tail0  = {8'd0, b};
      end else if ((need != 2'd0) && !eot) begin
        bytes_expected_next = need;
        bytes_held_next     = 2'd0;
        partial_value_next  = lead_bits;
      end else begin
        job.n_repl = job.n_repl + 3'd1;
      end
    end

    if (eot) begin
      bytes_expected_next = 2'd0;
      bytes_held_next     = 2'd0;
      partial_value_next  = '0;
    end
  end

  assign push = accept && ((job.n_repl != 3'd0) || (job.n_tail != 2'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_expected <= 2'd0;
      bytes_held     <= 2'd0;
      partial_value  <= '0;
    end else if (accept) begin
      bytes_expected <= bytes_expected_next;
      bytes_held     <= bytes_held_next;
      partial_value  <= partial_value_next;
    end
  end

endmodule

[src/u8u16_queue.sv]
// Short job queue between the front and the back end of the transcoder.
// Depends on u8u16_pkg.
module u8u16_queue #(
  parameter int Depth = u8u16_pkg::QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  u8u16_pkg::job_t          wr_job,
  input  logic                     pop,
  output u8u16_pkg::job_t          rd_job,
  output u8u16_pkg::queue_status_t status
);
  import u8u16_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  job_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign status.full  = (count == CntW'(Depth));
  assign status.empty = (count == '0);
  assign rd_job       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/u8u16_back.sv]
// Back end: plays out the code units of the job at the head of the queue,
// one beat per cycle while the output is ready. Depends on u8u16_pkg and u8u16_unit_if.
module u8u16_back (
  input  logic            clk,
  input  logic            rst,
  input  u8u16_pkg::job_t job,
  input  logic            empty,
  output logic            pop,
  u8u16_unit_if.source    units
);
  import u8u16_pkg::*;

  logic [2:0] idx;
  logic [2:0] total;
  logic       last;
  logic       fire;

  assign total = job.n_repl + {1'b0, job.n_tail};
  assign last  = ((idx + 3'd1) == total);
  assign fire  = units.valid && units.ready;
  assign pop   = fire && last;

  assign units.valid     = !empty;
  assign units.run_last  = last;
  assign units.text_last = last && job.eot;

  always_comb begin
    if (idx < job.n_repl) begin
      units.code_unit = REPL_UNIT;
    end else if (idx == job.n_repl) begin
      units.code_unit = job.tail0;
    end else begin
      units.code_unit = job.tail1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 3'd0;
    end else if (fire) begin
      idx <= last ? 3'd0 : idx + 3'd1;
    end
  end

endmodule

[tb/sv/u8u16_stream_checker.sv]
`timescale 1ns / 1ps
// Checker for the UTF-8 to UTF-16 transcoder: watches both channels, predicts units, compares.
// Depends on u8u16_pkg and the channel interfaces in u8u16_if.
module u8u16_stream_checker (
  input  logic   clk,
  input  logic   rst,
  u8u16_byte_if  bytes,
  u8u16_unit_if  units,
  output int     error_count,
  output int     units_pending
);
  import u8u16_pkg::*;

  localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
  localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
  localparam int          REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        run_last;
    logic        text_last;
  } unit_beat_t;

  // Decoder state of the open sequence.
  logic [1:0]  seq_need;
  logic [1:0]  seq_held;
  logic [20:0] seq_value;

  unit_beat_t byte_units[$];
  unit_beat_t expected_units[$];
  int         fault_total = 0;
  int         pending_now = 0;

  assign error_count   = fault_total;
  assign units_pending = pending_now;

  function automatic void push_unit(input logic [15:0] unit);
    unit_beat_t beat;
    beat = '{unit, 1'b0, 1'b0};
    if (byte_units.size() < 4) byte_units = {byte_units, beat};
  endfunction

  function automatic void close_sequence();
    seq_need  = '0;
    seq_held  = '0;
    seq_value = '0;
  endfunction

  // One replacement for the lead and one for every continuation byte held.
  function automatic void reject_sequence();
    for (int i = 0; i <= int'(seq_held); i++) push_unit(REPL_UNIT);
    close_sequence();
  endfunction

  function automatic void decode_fresh(input logic [7:0] b, input logic eot);
    logic [1:0] need;
    logic [4:0] bits;
    need = 2'd0;
    bits = '0;
    if (!b[7]) begin
      push_unit({8'h00, b});
      return;
    end
    if (b[7:5] == 3'b110) begin
      need = 2'd1;
      bits = b[4:0];
    end else if (b[7:4] == 4'b1110) begin
      need = 2'd2;
      bits = {1'b0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      need = 2'd3;
      bits = {2'b00, b[2:0]};
    end
    if (need == 2'd0 || eot) begin
      push_unit(REPL_UNIT);
      return;
    end
    seq_need  = need;
    seq_held  = '0;
    seq_value = {16'h0000, bits};
  endfunction

  function automatic void complete_sequence();
    logic [20:0] cp;
    logic [20:0] offset;
    logic        ok;
    cp = seq_value;
    if (seq_need == 2'd1)      ok = cp >= 21'h80;
    else if (seq_need == 2'd2) ok = cp >= 21'h800 && !(cp >= 21'hD800 && cp <= 21'hDFFF);
    else                       ok = cp >= 21'h10000 && cp <= 21'h10FFFF;
    if (!ok) begin
      reject_sequence();
      return;
    end
    if (cp <= 21'hFFFF) begin
      push_unit(cp[15:0]);
    end else begin
      offset = cp - 21'h10000;
      push_unit(HIGH_SURR_BASE + {6'd0, offset[19:10]});
      push_unit(LOW_SURR_BASE + {6'd0, offset[9:0]});
    end
    close_sequence();
  endfunction

  function automatic void predict_units(input logic [7:0] b, input logic eot);
    byte_units.delete();
    if (seq_need == 2'd0) begin
      decode_fresh(b, eot);
    end else if (b[7:6] == 2'b10) begin
      seq_value = {seq_value[14:0], b[5:0]};
      seq_held  = seq_held + 2'd1;
      if (seq_held >= seq_need) complete_sequence();
      else if (eot) reject_sequence();
    end else begin
      reject_sequence();
      decode_fresh(b, eot);
    end
    if (eot) close_sequence();
    if (byte_units.size() > 0) begin
      byte_units[byte_units.size() - 1].run_last  = 1'b1;
      byte_units[byte_units.size() - 1].text_last = eot;
    end
    expected_units = {expected_units, byte_units};
  endfunction

  function automatic void check_unit();
    unit_beat_t got;
    unit_beat_t want;
    got = '{units.code_unit, units.run_last, units.text_last};
    if (expected_units.size() == 0) begin
      fault_total++;
      if (fault_total <= REPORT_LIMIT)
        $display("%0t: unit %h run_last %b text_last %b arrived with nothing expected",
                 $realtime, got.code_unit, got.run_last, got.text_last);
    end else begin
      want = expected_units.pop_front();
      if (got != want) begin
        fault_total++;
        if (fault_total <= REPORT_LIMIT)
          $display("%0t: expected unit %h run_last %b text_last %b, got %h %b %b",
                   $realtime, want.code_unit, want.run_last, want.text_last,
                   got.code_unit, got.run_last, got.text_last);
      end
    end
  endfunction

  // The byte is predicted before the unit is compared, so even a unit
  // leaving in the same cycle as its byte would find its expectation.
  always @(posedge clk) begin
    if (rst) begin
      close_sequence();
      expected_units.delete();
    end else begin
      if (bytes.valid && bytes.ready) predict_units(bytes.in_byte, bytes.end_of_text);
      if (units.valid && units.ready) check_unit();
    end
    pending_now = expected_units.size();
  end

endmodule

[tb/sv/tb_utf8_to_utf16_transcoder.sv]
`timescale 1ns / 1ps
// Top of the transcoder testbench: clock, reset, byte stimulus, unit back-pressure, verdict.
// Depends on u8u16_pkg, u8u16_if, u8u16_stream_checker and the transcoder RTL.
module tb_utf8_to_utf16_transcoder;

  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_BYTES = 206;
  localparam int LONG_HOLD    = 300;
  localparam int TAIL_CYCLES  = 10;
  // The slowest correct run has every byte wait out the longest sender gap
  // and yield four units, each held by the longest receiver stall, plus the
  // long output hold. The limit keeps a wide margin above that.
  localparam int CYCLE_LIMIT  = 200000;

  logic clk;
  logic rst;

  u8u16_byte_if byte_ch ();
  u8u16_unit_if unit_ch ();

  int errors;
  int pending;

  // Stimulus bookkeeping of the sender and the receiver processes.
  int         bytes_sent = 0;
  bit         tx_steady  = 1'b0;
  bit         rx_steady  = 1'b0;
  bit         hold_units = 1'b0;
  logic [7:0] text_bytes[$];

  // Directed text: {end_of_text, byte}. It walks through plain ASCII at both
  // ends, an overlong pair, the highest two byte value, an encoded surrogate,
  // the highest code point (which comes out as a surrogate pair), a value
  // above the Unicode range (four replacements, the most one byte can cause),
  // a byte that can never appear, a stray continuation, a sequence broken by
  // an ASCII byte, a text ending inside a sequence, and a text ending on a lead.
  localparam logic [8:0] DIRECTED [24] = '{
    {1'b0, 8'h00}, {1'b1, 8'h7F},
    {1'b0, 8'hC0}, {1'b0, 8'h80},
    {1'b0, 8'hDF}, {1'b0, 8'hBF},
    {1'b0, 8'hED}, {1'b0, 8'hA0}, {1'b0, 8'h80},
    {1'b0, 8'hF4}, {1'b0, 8'h8F}, {1'b0, 8'hBF}, {1'b0, 8'hBF},
    {1'b0, 8'hF4}, {1'b0, 8'h90}, {1'b0, 8'h80}, {1'b0, 8'h80},
    {1'b0, 8'hFF},
    {1'b0, 8'h80},
    {1'b0, 8'hE2}, {1'b0, 8'h41},
    {1'b0, 8'hE1}, {1'b1, 8'h80},
    {1'b1, 8'hC3}
  };

  utf8_to_utf16_transcoder dut (
    .clk   (clk),
    .rst   (rst),
    .bytes (byte_ch),
    .units (unit_ch)
  );

  u8u16_stream_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .bytes         (byte_ch),
    .units         (unit_ch),
    .error_count   (errors),
    .units_pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here with the failing verdict.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_utf8_to_utf16_transcoder: done, errors");
    $finish;
  end

  // Offers one byte beat after a random gap and returns at the edge where it
  // was taken. With a zero gap, valid simply stays high for the next beat, so
  // valid never gets two assignments in the same time step.
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid       <= 1'b1;
    byte_ch.in_byte     <= b;
    byte_ch.end_of_text <= eot;
    do @(posedge clk); while (!byte_ch.ready);
    bytes_sent++;
  endtask

  // Stops offering and waits, on the falling edge where the checker's count
  // has settled, until every predicted unit has come out.
  task automatic wait_units_drained();
    byte_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Appends one byte to the piece of text being built.
  function automatic void add_byte(input logic [7:0] b);
    text_bytes = {text_bytes, b};
  endfunction

  // Appends the UTF-8 form of v in exactly len bytes, whether or not that
  // length is the shortest one; the overlong and out of range cases rely on it.
  function automatic void add_sequence(input int len, input logic [20:0] v);
    case (len)
      1: add_byte({1'b0, v[6:0]});
      2: begin
        add_byte({3'b110, v[10:6]});
        add_byte({2'b10, v[5:0]});
      end
      3: begin
        add_byte({4'b1110, v[15:12]});
        add_byte({2'b10, v[11:6]});
        add_byte({2'b10, v[5:0]});
      end
      default: begin
        add_byte({5'b11110, v[20:18]});
        add_byte({2'b10, v[17:12]});
        add_byte({2'b10, v[11:6]});
        add_byte({2'b10, v[5:0]});
      end
    endcase
  endfunction

  // Builds one piece of text and sends it. Most pieces are well-formed
  // characters of every length; the rest are values the decoder must reject,
  // sequences cut by a non-continuation byte, stray bytes and plain noise.
  // Any byte may end the text, which also cuts sequences short at random.
  task automatic send_random_piece();
    int          roll;
    int          len;
    int          keep;
    logic [20:0] cp;
    roll = $urandom_range(0, 15);
    text_bytes.delete();
    if (roll < 3) begin
      add_sequence(1, 21'($urandom_range(0, 'h7F)));
    end else if (roll < 5) begin
      add_sequence(2, 21'($urandom_range('h80, 'h7FF)));
    end else if (roll < 7) begin
      cp = 21'($urandom_range('h800, 'hFFFF));
      if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp - 21'h800;
      add_sequence(3, cp);
    end else if (roll < 9) begin
      add_sequence(4, 21'($urandom_range('h10000, 'h10FFFF)));
    end else if (roll < 11) begin
      // Complete sequences with a value the decoder has to refuse.
      case ($urandom_range(0, 4))
        0: add_sequence(2, 21'($urandom_range(0, 'h7F)));
        1: add_sequence(3, 21'($urandom_range(0, 'h7FF)));
        2: add_sequence(4, 21'($urandom_range(0, 'hFFFF)));
        3: add_sequence(3, 21'($urandom_range('hD800, 'hDFFF)));
        default: add_sequence(4, 21'($urandom_range('h110000, 'h1FFFFF)));
      endcase
    end else if (roll < 13) begin
      // A lead and none or some of its continuations, then a byte that breaks it.
      len  = $urandom_range(2, 4);
      keep = $urandom_range(1, len - 1);
      add_sequence(len, 21'($urandom));
      text_bytes = text_bytes[0:keep - 1];
      if ($urandom_range(0, 1) == 1) add_byte(8'($urandom_range(0, 'h7F)));
      else add_byte(8'($urandom_range('hC0, 'hFF)));
    end else if (roll == 13) begin
      if ($urandom_range(0, 1) == 1) add_byte(8'($urandom_range('h80, 'hBF)));
      else add_byte(8'($urandom_range('hF8, 'hFF)));
    end else begin
      add_byte(8'($urandom_range(0, 'hFF)));
    end
    foreach (text_bytes[i]) send_byte(text_bytes[i], $urandom_range(0, 11) == 0);
  endtask

  // Receiver: draws a random stall before every unit beat, except in steady
  // stretches where ready stays high. Once, on request of the sender, it holds
  // ready low for a long stretch so the job queue fills up and the block stops
  // taking bytes.
  initial begin
    int gap;
    unit_ch.ready <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    forever begin
      if (hold_units) begin
        gap        = LONG_HOLD;
        hold_units = 1'b0;
      end else begin
        gap = rx_steady ? 0 : $urandom_range(0, 4);
      end
      if ($urandom_range(0, 24) == 0) rx_steady = !rx_steady;
      if (gap > 0) begin
        unit_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      unit_ch.ready <= 1'b1;
      do @(posedge clk); while (!unit_ch.valid);
    end
  end

  // Sender and verdict.
  initial begin
    bit hold_done;
    bit pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    rst                 <= 1'b1;
    byte_ch.valid       <= 1'b0;
    byte_ch.in_byte     <= 8'h00;
    byte_ch.end_of_text <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
    wait_units_drained();

    while (bytes_sent < $size(DIRECTED) + RANDOM_BYTES) begin
      if ($urandom_range(0, 19) == 0) tx_steady = !tx_steady;
      // Long output hold while bytes keep coming: back-pressure reaches the input.
      if (!hold_done && bytes_sent >= 90) begin
        hold_units = 1'b1;
        hold_done  = 1'b1;
      end
      // One pause with the input idle until every unit has come out.
      if (!pause_done && bytes_sent >= 170) begin
        wait_units_drained();
        pause_done = 1'b1;
      end
      send_random_piece();
    end

    // Let every expected unit arrive, then give a stray extra unit time to show up.
    wait_units_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_utf8_to_utf16_transcoder: done, clean");
    end else begin
      $display("tb_utf8_to_utf16_transcoder: done, errors");
    end
    $finish;
  end

endmodule
